// ----- rtl/imh_pkg.sv -----
`default_nettype none
package imh_pkg;

  localparam int unsigned HeapDepth   = 1024;
  localparam int unsigned HandleCount = 1024;
  localparam int unsigned AddrW       = $clog2(HeapDepth);
  localparam int unsigned HAddrW      = $clog2(HandleCount);
  localparam int unsigned CntW        = AddrW + 1;
  localparam int unsigned HandleW     = 11;
  localparam int unsigned ValW        = 32;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELMIN = 2'd1,
    FUNC_DELH   = 2'd2,
    FUNC_CHANGE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_HDL  = 2'd2,
    ST_EXHAUST  = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic [HandleW-1:0]     handle;
  } slot_t;

endpackage
`default_nettype wire

// ----- rtl/imh_slot_ram.sv -----
`default_nettype none
module imh_slot_ram import imh_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire slot_t            wdata_i,
  input  wire logic             re_a_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  output slot_t                 rdata_a_o,
  input  wire logic             re_b_i,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output slot_t                 rdata_b_o
);

  slot_t mem [HeapDepth];
  slot_t rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_a_i) begin
      rdata_a_q <= mem[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule
`default_nettype wire

// ----- rtl/indexed_min_heap.sv -----
// The result is registered once the output is free; an item rejected at once, or one
// that names a dead handle, skips the sift and goes straight to the response.
// One item in flight; each sift level costs a slot-RAM read and a write-back.
// A held result stalls the input.
// Reset (async, active low) empties the heap at once; no memory clearing pass.
`default_nettype none
module indexed_min_heap import imh_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [1:0]             func_i,
  input  wire logic signed [ValW-1:0] value_i,
  input  wire logic [HandleW-1:0]     handle_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic signed [ValW-1:0]      min_value_o,
  output logic [HandleW-1:0]          heap_size_o,
  output logic                        is_empty_o,
  output logic [HandleW-1:0]          new_handle_o,
  output logic [1:0]                  status_o
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DMWAIT = 11'b00000000010,
    S_HWAIT  = 11'b00000000100,
    S_DHWAIT = 11'b00000001000,
    S_UPRD   = 11'b00000010000,
    S_UPCMP  = 11'b00000100000,
    S_DNRD   = 11'b00001000000,
    S_DNCMP  = 11'b00010000000,
    S_PLACE  = 11'b00100000000,
    S_FIN    = 11'b01000000000,
    S_RESP   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    issued_q, issued_d;
  logic [CntW-1:0]    pos_q, pos_d;
  logic               moved_q, moved_d;
  slot_t              cur_q, cur_d;
  func_e              func_q, func_d;
  status_e            stat_q, stat_d;
  logic [HandleW-1:0] given_q, given_d;

  logic                   ovalid_q;
  logic signed [ValW-1:0] omin_q;
  logic [HandleW-1:0]     osize_q, ohdl_q;
  logic                   oempty_q;
  logic [1:0]             ostat_q;

  // slot RAM ports
  logic             s_we, s_re_a, s_re_b;
  logic [AddrW-1:0] s_waddr, s_raddr_a, s_raddr_b;
  slot_t            s_wdata, s_rd_a, s_rd_b;

  // handle-to-slot RAM: {live, slot}
  logic [CntW:0]     h2s_mem [HandleCount];
  logic [CntW:0]     h_rd_q, h_wdata;
  logic              h_we, h_re;
  logic [HAddrW-1:0] h_waddr, h_raddr;

  imh_slot_ram u_slot_ram (
    .clk_i,
    .we_i      (s_we),
    .waddr_i   (s_waddr),
    .wdata_i   (s_wdata),
    .re_a_i    (s_re_a),
    .raddr_a_i (s_raddr_a),
    .rdata_a_o (s_rd_a),
    .re_b_i    (s_re_b),
    .raddr_b_i (s_raddr_b),
    .rdata_b_o (s_rd_b)
  );

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      h2s_mem[h_waddr] <= h_wdata;
    end
    if (h_re) begin
      h_rd_q <= h2s_mem[h_raddr];
    end
  end

  logic               accept, out_free;
  logic [CntW-1:0]    parent, hslot;
  logic [CntW:0]      lchild, rchild;
  logic               l_ok, r_ok, sel_l, sel_r;
  logic signed [ValW-1:0] l_cmp_v;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !ovalid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  assign parent = pos_q >> 1;
  assign lchild = {pos_q, 1'b0};
  assign rchild = lchild + (CntW+1)'(1);
  assign l_ok   = lchild <= {1'b0, count_q};
  assign r_ok   = rchild <= {1'b0, count_q};
  assign sel_l  = l_ok && (s_rd_a.value < cur_q.value);
  assign l_cmp_v = sel_l ? s_rd_a.value : cur_q.value;
  assign sel_r  = r_ok && (s_rd_b.value < l_cmp_v);
  assign hslot  = h_rd_q[CntW-1:0];

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    issued_d = issued_q;
    pos_d    = pos_q;
    moved_d  = moved_q;
    cur_d    = cur_q;
    func_d   = func_q;
    stat_d   = stat_q;
    given_d  = given_q;
    s_we = 1'b0; s_waddr = '0; s_wdata = cur_q;
    s_re_a = 1'b0; s_raddr_a = '0;
    s_re_b = 1'b0; s_raddr_b = '0;
    h_we = 1'b0; h_waddr = '0; h_wdata = '0;
    h_re = 1'b0; h_raddr = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          func_d  = func_e'(func_i);
          stat_d  = ST_OK;
          given_d = '0;
          moved_d = 1'b0;
          case (func_e'(func_i))
            FUNC_INSERT: begin
              if (count_q >= CntW'(HeapDepth) || issued_q >= CntW'(HandleCount)) begin
                stat_d  = ST_EXHAUST;
                state_d = S_FIN;
              end else begin
                count_d  = count_q + CntW'(1);
                issued_d = issued_q + CntW'(1);
                given_d  = HandleW'(issued_q + CntW'(1));
                cur_d.value  = value_i;
                cur_d.handle = HandleW'(issued_q + CntW'(1));
                pos_d   = count_q + CntW'(1);
                state_d = S_UPRD;
              end
            end
            FUNC_DELMIN: begin
              if (count_q == '0) begin
                stat_d  = ST_EMPTY;
                state_d = S_FIN;
              end else begin
                s_re_a = 1'b1; s_raddr_a = '0;
                s_re_b = 1'b1; s_raddr_b = AddrW'(count_q - CntW'(1));
                state_d = S_DMWAIT;
              end
            end
            default: begin
              if (handle_i == '0 || CntW'(handle_i) > issued_q) begin
                stat_d  = ST_BAD_HDL;
                state_d = S_FIN;
              end else begin
                h_re = 1'b1;
                h_raddr = HAddrW'(handle_i - HandleW'(1));
                cur_d.value  = value_i;
                cur_d.handle = handle_i;
                state_d = S_HWAIT;
              end
            end
          endcase
        end
      end
      S_DMWAIT: begin
        h_we = 1'b1;
        h_waddr = HAddrW'(s_rd_a.handle - HandleW'(1));
        h_wdata = '0;
        cur_d   = s_rd_b;
        count_d = count_q - CntW'(1);
        pos_d   = CntW'(1);
        state_d = (count_q == CntW'(1)) ? S_FIN : S_UPRD;
      end
      S_HWAIT: begin
        if (!h_rd_q[CntW]) begin
          stat_d  = ST_BAD_HDL;
          state_d = S_FIN;
        end else if (func_q == FUNC_CHANGE) begin
          pos_d   = hslot;
          state_d = S_UPRD;
        end else begin
          h_we = 1'b1;
          h_waddr = HAddrW'(cur_q.handle - HandleW'(1));
          h_wdata = '0;
          pos_d   = hslot;
          if (hslot == count_q) begin
            count_d = count_q - CntW'(1);
            state_d = S_FIN;
          end else begin
            s_re_b = 1'b1; s_raddr_b = AddrW'(count_q - CntW'(1));
            state_d = S_DHWAIT;
          end
        end
      end
      S_DHWAIT: begin
        cur_d   = s_rd_b;
        count_d = count_q - CntW'(1);
        state_d = S_UPRD;
      end
      S_UPRD: begin
        if (pos_q == CntW'(1)) begin
          state_d = moved_q ? S_PLACE : S_DNRD;
        end else begin
          s_re_a = 1'b1; s_raddr_a = AddrW'(parent - CntW'(1));
          state_d = S_UPCMP;
        end
      end
      S_UPCMP: begin
        if (s_rd_a.value > cur_q.value) begin
          s_we = 1'b1; s_waddr = AddrW'(pos_q - CntW'(1)); s_wdata = s_rd_a;
          h_we = 1'b1; h_waddr = HAddrW'(s_rd_a.handle - HandleW'(1));
          h_wdata = {1'b1, pos_q};
          pos_d   = parent;
          moved_d = 1'b1;
          state_d = S_UPRD;
        end else begin
          state_d = moved_q ? S_PLACE : S_DNRD;
        end
      end
      S_DNRD: begin
        if (!l_ok) begin
          state_d = S_PLACE;
        end else begin
          s_re_a = 1'b1; s_raddr_a = AddrW'(lchild - (CntW+1)'(1));
          s_re_b = 1'b1; s_raddr_b = AddrW'(lchild);
          state_d = S_DNCMP;
        end
      end
      S_DNCMP: begin
        if (sel_l || sel_r) begin
          s_we = 1'b1; s_waddr = AddrW'(pos_q - CntW'(1));
          s_wdata = sel_r ? s_rd_b : s_rd_a;
          h_we = 1'b1;
          h_waddr = HAddrW'(s_wdata.handle - HandleW'(1));
          h_wdata = {1'b1, pos_q};
          pos_d   = sel_r ? CntW'(rchild) : CntW'(lchild);
          state_d = S_DNRD;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        s_we = 1'b1; s_waddr = AddrW'(pos_q - CntW'(1)); s_wdata = cur_q;
        h_we = 1'b1; h_waddr = HAddrW'(cur_q.handle - HandleW'(1));
        h_wdata = {1'b1, pos_q};
        state_d = S_FIN;
      end
      S_FIN: begin
        s_re_a = 1'b1; s_raddr_a = '0;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      issued_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      issued_q <= issued_d;
      if (state_q == S_RESP && out_free) begin
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    moved_q <= moved_d;
    cur_q   <= cur_d;
    func_q  <= func_d;
    stat_q  <= stat_d;
    given_q <= given_d;
    if (state_q == S_RESP && out_free) begin
      omin_q   <= (count_q == '0) ? '0 : s_rd_a.value;
      osize_q  <= HandleW'(count_q);
      oempty_q <= (count_q == '0);
      ohdl_q   <= given_q;
      ostat_q  <= stat_q;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign min_value_o  = omin_q;
  assign heap_size_o  = osize_q;
  assign is_empty_o   = oempty_q;
  assign new_handle_o = ohdl_q;
  assign status_o     = ostat_q;

endmodule
`default_nettype wire
